### rtl/core/rs3_pkg.sv
package rs3_pkg;

   localparam int MAX_WIDTH_DEF     = 2048;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int ELEV_W   = 32;
   localparam int CELL_W   = 33;
   localparam int ROW_W    = 16;
   localparam int COL_W    = 11;
   localparam int SLOPE_W  = 15;
   localparam int FW_W     = 12;
   localparam int FH_W     = 16;
   localparam int SCALE_W  = 32;
   localparam int RCNT_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int G_W      = 36;
   localparam int Z_W      = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SCALE    = 2'd2;

   localparam logic [FW_W-1:0]    FRAME_WIDTH_RST  = 12'd2048;
   localparam logic [FH_W-1:0]    FRAME_HEIGHT_RST = 16'd1;
   localparam logic [SCALE_W-1:0] INV_SCALE_RST    = 32'd2097152;

   localparam logic [63:0]        REF_ONE     = 64'd16777216;
   localparam logic [SLOPE_W-1:0] Q88_MAX     = 15'd23040;
   localparam logic [63:0]        RAD2DEG_Q22 = 64'd240315917;

   typedef struct packed {
      logic signed [ELEV_W-1:0] elevation;
      logic                     defined;
      logic                     padding;
   } req_type;

   typedef struct packed {
      logic [SLOPE_W-1:0] slope_deg;
      logic               slope_defined;
      logic [ROW_W-1:0]   pixel_row;
      logic [COL_W-1:0]   pixel_col;
      logic               last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [8:0][CELL_W-1:0] cells;
      logic [ROW_W-1:0]       row;
      logic [COL_W-1:0]       col;
      logic                   last;
   } job_type;

   function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] i);
      logic [63:0] t;
      t = 64'd0;
      unique case (i)
         5'd0:  t = 64'd188743680;
         5'd1:  t = 64'd111421900;
         5'd2:  t = 64'd58872272;
         5'd3:  t = 64'd29884485;
         5'd4:  t = 64'd15000234;
         5'd5:  t = 64'd7507429;
         5'd6:  t = 64'd3754631;
         5'd7:  t = 64'd1877430;
         5'd8:  t = 64'd938729;
         5'd9:  t = 64'd469366;
         5'd10: t = 64'd234683;
         5'd11: t = 64'd117342;
         5'd12: t = 64'd58671;
         5'd13: t = 64'd29335;
         5'd14: t = 64'd14668;
         5'd15: t = 64'd7334;
         default: t = (RAD2DEG_Q22 + (64'd1 << (i - 5'd1))) >> i;
      endcase
      return Z_W'(t);
   endfunction

endpackage

### rtl/core/rs3_ram.sv
module rs3_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/rs3_queue.sv
module rs3_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rs3_pkg::job_type  push_data,
   output logic              full,
   input  logic              pop,
   output rs3_pkg::job_type  pop_data,
   output logic              empty
);
   import rs3_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/rs3_front.sv
module rs3_front #(
   parameter int MAX_WIDTH = rs3_pkg::MAX_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      restart,
   input  logic [rs3_pkg::FW_W-1:0]  frame_width,
   input  logic [rs3_pkg::FH_W-1:0]  frame_height,
   input  logic                      req_push,
   output logic                      req_full,
   input  rs3_pkg::req_type          req_data,
   output logic                      q_push,
   output rs3_pkg::job_type          q_data,
   input  logic                      q_full
);
   import rs3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int AW = $clog2(MAX_WIDTH);

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_READ = 2'b10
   } fstate_type;

   fstate_type             state_ff, state_in;
   logic [CW-1:0]          c_ff, c_in;
   logic [RCNT_W-1:0]      r_ff, r_in;
   req_type                item_ff;
   logic [8:0][CELL_W-1:0] win_ff, win_in;

   logic [CW-1:0]          w_eff, c_use, c_inc;
   logic [FH_W-1:0]        h_eff;
   logic                   accept, c0, last;
   logic [CELL_W-1:0]      up_rd, mid_rd, cu, cm, cnew;
   logic [8:0][CELL_W-1:0] sh;
   logic                   ram_we;

   always_comb begin
      if (frame_width == '0) begin
         w_eff = CW'(1);
      end else if (int'(frame_width) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(frame_width);
      end
      h_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
      c_use = (c_ff >= w_eff) ? '0 : c_ff;
   end

   assign req_full = (state_ff != F_IDLE) || q_full;
   assign accept   = req_push && !req_full;
   assign ram_we   = state_ff == F_READ;

   rs3_ram #(.WIDTH(CELL_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock (clock),
      .we    (ram_we),
      .addr  (c_use[AW-1:0]),
      .wdata (cm),
      .rdata (up_rd)
   );

   rs3_ram #(.WIDTH(CELL_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock (clock),
      .we    (ram_we),
      .addr  (c_use[AW-1:0]),
      .wdata (cnew),
      .rdata (mid_rd)
   );

   always_comb begin
      cnew = '0;
      if (!item_ff.padding && (r_ff < {1'b0, h_eff}) && item_ff.defined) begin
         cnew = {1'b1, item_ff.elevation};
      end
      cu    = (r_ff >= RCNT_W'(2)) ? up_rd : '0;
      cm    = (r_ff >= RCNT_W'(1)) ? mid_rd : '0;
      c0    = c_use == '0;
      last  = c0 && (r_ff - RCNT_W'(2) == {1'b0, h_eff} - RCNT_W'(1));
      c_inc = c_use + CW'(1);

      for (int rr = 0; rr < 3; rr++) begin
         sh[rr*3]   = win_ff[rr*3+1];
         sh[rr*3+1] = win_ff[rr*3+2];
      end
      sh[2] = c0 ? '0 : cu;
      sh[5] = c0 ? '0 : cm;
      sh[8] = c0 ? '0 : cnew;

      q_data.cells = sh;
      q_data.row   = c0 ? ROW_W'(r_ff - RCNT_W'(2)) : ROW_W'(r_ff - RCNT_W'(1));
      q_data.col   = c0 ? COL_W'(w_eff - CW'(1)) : COL_W'(c_use - CW'(1));
      q_data.last  = last;
      q_push       = ram_we && (c0 ? (r_ff >= RCNT_W'(2)) : (r_ff >= RCNT_W'(1)));

      if (c0) begin
         win_in    = '0;
         win_in[2] = cu;
         win_in[5] = cm;
         win_in[8] = cnew;
      end else begin
         win_in = sh;
      end

      state_in = state_ff;
      c_in     = c_ff;
      r_in     = r_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (restart) begin
               c_in = '0;
               r_in = '0;
            end else if (accept) begin
               state_in = F_READ;
            end
         end
         F_READ: begin
            state_in = F_IDLE;
            if (last) begin
               c_in = '0;
               r_in = '0;
            end else if (c_inc >= w_eff) begin
               c_in = '0;
               r_in = r_ff + RCNT_W'(1);
            end else begin
               c_in = c_inc;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         c_ff     <= '0;
         r_ff     <= '0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         c_ff     <= c_in;
         r_ff     <= r_in;
         if (ram_we) begin
            win_ff <= win_in;
         end
      end
      if (accept) begin
         item_ff <= req_data;
      end
   end

endmodule

### rtl/core/rs3_back.sv
module rs3_back #(
   parameter int CORDIC_STAGES = rs3_pkg::CORDIC_STAGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rs3_pkg::SCALE_W-1:0] inv_scale,
   input  logic                        q_empty,
   output logic                        q_pop,
   input  rs3_pkg::job_type            q_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output rs3_pkg::rsp_type            rsp_data
);
   import rs3_pkg::*;

   localparam int STW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

   typedef enum logic [6:0] {
      B_IDLE = 7'b0000001,
      B_MULX = 7'b0000010,
      B_MULY = 7'b0000100,
      B_NORM = 7'b0001000,
      B_ROT  = 7'b0010000,
      B_FIN  = 7'b0100000,
      B_OUT  = 7'b1000000
   } bstate_type;

   bstate_type              state_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [COL_W-1:0]        col_ff;
   logic                    last_ff, sdef_ff;
   logic [31:0]             a_ff, b_ff;
   logic [63:0]             ref_ff, mx_ff, my_ff;
   logic signed [Z_W-1:0]   x_ff, y_ff, z_ff, m_ff;
   logic [1:0]              pass_ff;
   logic [STW-1:0]          stage_ff;
   logic [SLOPE_W-1:0]      slope_ff;
   logic                    out_valid_ff;
   rsp_type                 out_ff;

   logic signed [G_W-1:0]   v [9];
   logic signed [G_W-1:0]   e, gx, gy;
   logic [G_W-1:0]          ax, ay, axy;
   logic [1:0]              pre_sh;
   logic [31:0]             mul_a;
   logic [63:0]             prod, top;
   logic signed [Z_W-1:0]   xs, ys, x_nx, y_nx, z_nx, at, zr;
   logic                    ypos, stage_last, out_free;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      e = G_W'(signed'(q_data.cells[4][ELEV_W-1:0]));
      for (int k = 0; k < 9; k++) begin
         v[k] = q_data.cells[k][CELL_W-1] ? G_W'(signed'(q_data.cells[k][ELEV_W-1:0])) : e;
      end
      gx  = (v[2] + (v[5] <<< 1) + v[8]) - (v[0] + (v[3] <<< 1) + v[6]);
      gy  = (v[6] + (v[7] <<< 1) + v[8]) - (v[0] + (v[1] <<< 1) + v[2]);
      ax  = gx[G_W-1] ? G_W'(-gx) : G_W'(gx);
      ay  = gy[G_W-1] ? G_W'(-gy) : G_W'(gy);
      axy = ax | ay;
      if (axy[G_W-1:33] != '0) begin
         pre_sh = 2'd2;
      end else if (axy[32] != 1'b0) begin
         pre_sh = 2'd1;
      end else begin
         pre_sh = 2'd0;
      end

      mul_a = (state_ff == B_MULX) ? a_ff : b_ff;
      prod  = 64'(mul_a) * 64'(inv_scale);

      top = (mx_ff > my_ff) ? mx_ff : my_ff;
      if (ref_ff > top) begin
         top = ref_ff;
      end

      xs         = x_ff >>> stage_ff;
      ys         = y_ff >>> stage_ff;
      ypos       = !y_ff[Z_W-1] && (y_ff != '0);
      at         = signed'(atan_entry(5'(stage_ff)));
      x_nx       = ypos ? x_ff + ys : x_ff - ys;
      y_nx       = ypos ? y_ff - xs : y_ff + xs;
      z_nx       = ypos ? z_ff + at : z_ff - at;
      stage_last = stage_ff == STW'(CORDIC_STAGES - 1);
      zr         = (z_ff + Z_W'(8192)) >>> 14;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == B_OUT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  row_ff   <= q_data.row;
                  col_ff   <= q_data.col;
                  last_ff  <= q_data.last;
                  sdef_ff  <= q_data.cells[4][CELL_W-1];
                  a_ff     <= 32'(ax >> pre_sh);
                  b_ff     <= 32'(ay >> pre_sh);
                  ref_ff   <= REF_ONE >> pre_sh;
                  slope_ff <= '0;
                  state_ff <= q_data.cells[4][CELL_W-1] ? B_MULX : B_OUT;
               end
            end
            B_MULX: begin
               mx_ff    <= prod;
               state_ff <= B_MULY;
            end
            B_MULY: begin
               my_ff    <= prod;
               state_ff <= B_NORM;
            end
            B_NORM: begin
               if (mx_ff == '0 && my_ff == '0) begin
                  state_ff <= B_OUT;
               end else if (top[63:30] != '0) begin
                  mx_ff  <= mx_ff >> 1;
                  my_ff  <= my_ff >> 1;
                  ref_ff <= ref_ff >> 1;
               end else if (top[63:29] == '0) begin
                  mx_ff  <= mx_ff << 1;
                  my_ff  <= my_ff << 1;
                  ref_ff <= ref_ff << 1;
               end else begin
                  x_ff     <= signed'(Z_W'(mx_ff));
                  y_ff     <= signed'(Z_W'(my_ff));
                  z_ff     <= '0;
                  pass_ff  <= 2'd0;
                  stage_ff <= '0;
                  state_ff <= B_ROT;
               end
            end
            B_ROT: begin
               if (!stage_last) begin
                  x_ff     <= x_nx;
                  y_ff     <= y_nx;
                  z_ff     <= z_nx;
                  stage_ff <= stage_ff + STW'(1);
               end else begin
                  stage_ff <= '0;
                  pass_ff  <= pass_ff + 2'd1;
                  unique case (pass_ff)
                     2'd0: begin
                        m_ff <= x_nx;
                        x_ff <= signed'(Z_W'(ref_ff));
                        y_ff <= '0;
                        z_ff <= '0;
                     end
                     2'd1: begin
                        x_ff <= x_nx;
                        y_ff <= m_ff;
                        z_ff <= '0;
                     end
                     default: begin
                        z_ff     <= z_nx;
                        state_ff <= B_FIN;
                     end
                  endcase
               end
            end
            B_FIN: begin
               if (z_ff <= 0) begin
                  slope_ff <= '0;
               end else if (zr > signed'(Z_W'(Q88_MAX))) begin
                  slope_ff <= Q88_MAX;
               end else begin
                  slope_ff <= SLOPE_W'(zr);
               end
               state_ff <= B_OUT;
            end
            B_OUT: begin
               if (out_free) begin
                  out_ff.slope_deg     <= slope_ff;
                  out_ff.slope_defined <= sdef_ff;
                  out_ff.pixel_row     <= row_ff;
                  out_ff.pixel_col     <= col_ff;
                  out_ff.last_of_frame <= last_ff;
                  state_ff             <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/raster_slope_3x3_top.sv
// Horn 3x3 terrain slope over a raster stream of elevation pixels.
// Input queue: req_data (elevation, defined, padding) transfers when req_push
// is high and req_full low. Pixels come in raster order; after the frame the
// host sends frame_width+1 padding items to flush the last rows.
// Result queue: rsp_data is valid while rsp_empty is low and transfers on
// rsp_pop. One result per pixel, emitted once the item at its lower-right
// neighbour position has been taken.
// Register port: csr_index/csr_wdata transfer on csr_valid and csr_ready
// (ready is always high). 0 frame_width, 1 frame_height, 2 inv_scale (Q8.24).
// Width or height writes restart the frame; write only while idle.
// Front: line store read, then write and window update; no new item meanwhile.
// Back: two multiplies, normalise shifts, then the single shared CORDIC stage
// run three times per pixel with a defined centre and a nonzero gradient.
// A 2-entry queue sits between front and back; when the receiver stalls the
// back holds its result and the front fills the queue, then raises req_full.
// Reset (synchronous) clears counters, window and queues; registers go to
// frame_width 2048, frame_height 1, inv_scale 2^21. Line stores need no clear.
module raster_slope_3x3_top #(
   parameter int MAX_WIDTH     = rs3_pkg::MAX_WIDTH_DEF,
   parameter int CORDIC_STAGES = rs3_pkg::CORDIC_STAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  rs3_pkg::req_type               req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output rs3_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rs3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rs3_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rs3_pkg::*;

   logic [FW_W-1:0]    width_ff;
   logic [FH_W-1:0]    height_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               csr_wr, restart;
   logic               q_push, q_full, q_pop, q_empty;
   job_type            q_wdata, q_rdata;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign restart   = csr_wr && (csr_index == CSR_FRAME_WIDTH
                                 || csr_index == CSR_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RST;
         height_ff <= FRAME_HEIGHT_RST;
         scale_ff  <= INV_SCALE_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata[FH_W-1:0];
            CSR_INV_SCALE:    scale_ff  <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   rs3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .q_push       (q_push),
      .q_data       (q_wdata),
      .q_full       (q_full)
   );

   rs3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   rs3_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .inv_scale (scale_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_rdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
